### hdl/touch_sample_qualify_calibrate_top_macros.svh
// Assertion macros used by the touch calibration RTL
`ifndef TOUCH_SAMPLE_QUALIFY_CALIBRATE_TOP_MACROS_SVH
`define TOUCH_SAMPLE_QUALIFY_CALIBRATE_TOP_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define TSQC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("touch calibration check failed");

// Next-cycle implication checked outside reset
`define TSQC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("touch calibration check failed");

`endif

### hdl/tsqc_pkg.sv
// Shared constants and types for the touch sample qualify and calibrate block
package tsqc_pkg;

  localparam int unsigned PANEL_WIDTH  = 480;
  localparam int unsigned PANEL_HEIGHT = 272;
  localparam int unsigned DIV_STEPS    = 32;

  // register indexes
  typedef enum logic [2:0] {
    REG_X_OFFSET  = 3'd0,
    REG_X_GAIN_X  = 3'd1,
    REG_X_GAIN_Y  = 3'd2,
    REG_Y_OFFSET  = 3'd3,
    REG_Y_GAIN_X  = 3'd4,
    REG_Y_GAIN_Y  = 3'd5,
    REG_SCALE     = 3'd6,
    REG_THRESHOLD = 3'd7
  } reg_idx_t;

  // side data that travels with each word through the divider
  typedef struct packed {
    logic        vld;
    logic        agree;
    logic [11:0] ax;
    logic [11:0] ay;
    logic        neg_x;
    logic        neg_y;
  } side_t;

endpackage

### hdl/touch_sample_qualify_calibrate_top.sv
// Top level of the touch sample qualify and calibrate block
// Use: the input channel (in_valid/in_ready) takes one word per cycle holding two
// raw (x,y) ADC readings. The pair agrees when both absolute differences are below
// agree_threshold; the readings are then averaged and mapped through the affine
// calibration set over the APB port, divided by scale_divisor (truncating toward
// zero), kept to 16 bits and clamped to the panel size.
// The output channel (out_valid/out_ready) delivers one result word per input word,
// in order; disagreeing pairs come out with valid_res low and all fields zero.
// Stages: averaging, products, sums, magnitude, then 32 restoring divider steps
// (one quotient bit per stage, both axes side by side), then the clamp and output
// register. Throughput is one word per cycle. When the receiver stalls, the whole
// pipeline holds and in_ready drops in the same cycle; nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads the default calibration (unit
// gains, divisor 65536, threshold 50); pready is always high. The user must write
// configuration only while the pipeline is empty; the block does not enforce it.
module touch_sample_qualify_calibrate_top
  import tsqc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] first_raw_x,
  input  logic [11:0] first_raw_y,
  input  logic [11:0] second_raw_x,
  input  logic [11:0] second_raw_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        valid_res,
  output logic [11:0] avg_raw_x,
  output logic [11:0] avg_raw_y,
  output logic [9:0]  screen_x,
  output logic [9:0]  screen_y,
  output logic        clamped
);

`include "touch_sample_qualify_calibrate_top_macros.svh"

  // configuration registers
  logic [31:0] x_offset, x_gain_x, x_gain_y, y_offset, y_gain_x, y_gain_y;
  logic [30:0] scale_divisor;
  logic [12:0] agree_threshold;
  reg_idx_t    widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset        <= 32'd0;
      x_gain_x        <= 32'd65536;
      x_gain_y        <= 32'd0;
      y_offset        <= 32'd0;
      y_gain_x        <= 32'd0;
      y_gain_y        <= 32'd65536;
      scale_divisor   <= 31'd65536;
      agree_threshold <= 13'd50;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        REG_X_OFFSET:  x_offset        <= pwdata;
        REG_X_GAIN_X:  x_gain_x        <= pwdata;
        REG_X_GAIN_Y:  x_gain_y        <= pwdata;
        REG_Y_OFFSET:  y_offset        <= pwdata;
        REG_Y_GAIN_X:  y_gain_x        <= pwdata;
        REG_Y_GAIN_Y:  y_gain_y        <= pwdata;
        REG_SCALE:     scale_divisor   <= pwdata[30:0];
        REG_THRESHOLD: agree_threshold <= pwdata[12:0];
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (widx)
      REG_X_OFFSET:  prdata = x_offset;
      REG_X_GAIN_X:  prdata = x_gain_x;
      REG_X_GAIN_Y:  prdata = x_gain_y;
      REG_Y_OFFSET:  prdata = y_offset;
      REG_Y_GAIN_X:  prdata = y_gain_x;
      REG_Y_GAIN_Y:  prdata = y_gain_y;
      REG_SCALE:     prdata = {1'b0, scale_divisor};
      REG_THRESHOLD: prdata = {19'd0, agree_threshold};
    endcase
  end

  // global advance: the whole pipeline moves unless the output is stalled
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: agreement and averages
  logic [11:0] dx, dy;
  logic [12:0] sumx, sumy;
  side_t       s1;
  assign dx   = (first_raw_x > second_raw_x) ? first_raw_x - second_raw_x
                                             : second_raw_x - first_raw_x;
  assign dy   = (first_raw_y > second_raw_y) ? first_raw_y - second_raw_y
                                             : second_raw_y - first_raw_y;
  assign sumx = {1'b0, first_raw_x} + {1'b0, second_raw_x};
  assign sumy = {1'b0, first_raw_y} + {1'b0, second_raw_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld <= 1'b0;
    end else if (en) begin
      s1.vld <= in_valid;
    end
    if (en) begin
      s1.agree <= ({1'b0, dx} < agree_threshold) && ({1'b0, dy} < agree_threshold);
      s1.ax    <= sumx[12:1];
      s1.ay    <= sumy[12:1];
      s1.neg_x <= 1'b0;
      s1.neg_y <= 1'b0;
    end
  end

  // stage 2: products, wrapping to 32 bits
  side_t       s2;
  logic [31:0] pxx, pxy, pyx, pyy;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.vld <= 1'b0;
    end else if (en) begin
      s2.vld <= s1.vld;
    end
    if (en) begin
      s2.agree <= s1.agree;
      s2.ax    <= s1.ax;
      s2.ay    <= s1.ay;
      s2.neg_x <= 1'b0;
      s2.neg_y <= 1'b0;
      pxx      <= 32'(x_gain_x * {20'd0, s1.ax});
      pxy      <= 32'(x_gain_y * {20'd0, s1.ay});
      pyx      <= 32'(y_gain_x * {20'd0, s1.ax});
      pyy      <= 32'(y_gain_y * {20'd0, s1.ay});
    end
  end

  // stage 3: sums
  side_t       s3;
  logic [31:0] sum_x, sum_y;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3.vld <= 1'b0;
    end else if (en) begin
      s3.vld <= s2.vld;
    end
    if (en) begin
      s3.agree <= s2.agree;
      s3.ax    <= s2.ax;
      s3.ay    <= s2.ay;
      s3.neg_x <= 1'b0;
      s3.neg_y <= 1'b0;
      sum_x    <= x_offset + pxx + pxy;
      sum_y    <= y_offset + pyx + pyy;
    end
  end

  // divider pipeline: word holds numerator bits shifting out, quotient bits in
  side_t       dside [0:DIV_STEPS];
  logic [31:0] wx [0:DIV_STEPS];
  logic [31:0] wy [0:DIV_STEPS];
  logic [30:0] rx [0:DIV_STEPS];
  logic [30:0] ry [0:DIV_STEPS];
  logic [31:0] wx_next [0:DIV_STEPS-1];
  logic [31:0] wy_next [0:DIV_STEPS-1];
  logic [30:0] rx_next [0:DIV_STEPS-1];
  logic [30:0] ry_next [0:DIV_STEPS-1];

  // one restoring step per stage, for both axes
  always_comb begin
    logic [31:0] tx, ty;
    logic        gx, gy;
    for (int k = 0; k < DIV_STEPS; k++) begin
      tx = {rx[k], wx[k][31]};
      ty = {ry[k], wy[k][31]};
      gx = tx >= {1'b0, scale_divisor};
      gy = ty >= {1'b0, scale_divisor};
      rx_next[k] = gx ? 31'(tx - {1'b0, scale_divisor}) : tx[30:0];
      ry_next[k] = gy ? 31'(ty - {1'b0, scale_divisor}) : ty[30:0];
      wx_next[k] = {wx[k][30:0], gx};
      wy_next[k] = {wy[k][30:0], gy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) dside[k].vld <= 1'b0;
    end else if (en) begin
      dside[0].vld <= s3.vld;
      for (int k = 0; k < DIV_STEPS; k++) dside[k+1].vld <= dside[k].vld;
    end
    if (en) begin
      // load magnitudes and signs
      dside[0].agree <= s3.agree;
      dside[0].ax    <= s3.ax;
      dside[0].ay    <= s3.ay;
      dside[0].neg_x <= sum_x[31];
      dside[0].neg_y <= sum_y[31];
      wx[0] <= sum_x[31] ? 32'(-sum_x) : sum_x;
      wy[0] <= sum_y[31] ? 32'(-sum_y) : sum_y;
      rx[0] <= 31'd0;
      ry[0] <= 31'd0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        dside[k+1].agree <= dside[k].agree;
        dside[k+1].ax    <= dside[k].ax;
        dside[k+1].ay    <= dside[k].ay;
        dside[k+1].neg_x <= dside[k].neg_x;
        dside[k+1].neg_y <= dside[k].neg_y;
        wx[k+1] <= wx_next[k];
        wy[k+1] <= wy_next[k];
        rx[k+1] <= rx_next[k];
        ry[k+1] <= ry_next[k];
      end
    end
  end

  // sign restore, 16-bit truncation and panel clamp
  logic [15:0] qx, qy;
  logic        over;
  side_t       dl;
  assign dl   = dside[DIV_STEPS];
  assign qx   = (scale_divisor == 31'd0) ? 16'd0 :
                dl.neg_x ? 16'(-wx[DIV_STEPS][15:0]) : wx[DIV_STEPS][15:0];
  assign qy   = (scale_divisor == 31'd0) ? 16'd0 :
                dl.neg_y ? 16'(-wy[DIV_STEPS][15:0]) : wy[DIV_STEPS][15:0];
  assign over = (qx > 16'(PANEL_WIDTH)) || (qy > 16'(PANEL_HEIGHT));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dl.vld;
    end
    if (en) begin
      valid_res <= dl.agree;
      avg_raw_x <= dl.agree ? dl.ax : 12'd0;
      avg_raw_y <= dl.agree ? dl.ay : 12'd0;
      clamped   <= dl.agree && over;
      if (!dl.agree) begin
        screen_x <= 10'd0;
        screen_y <= 10'd0;
      end else if (over) begin
        screen_x <= 10'(PANEL_WIDTH);
        screen_y <= 10'(PANEL_HEIGHT);
      end else begin
        screen_x <= qx[9:0];
        screen_y <= qy[9:0];
      end
    end
  end

  // checks
  `TSQC_ASSERT_IMP(a_invalid_zero, out_valid && !valid_res,
    screen_x == 10'd0 && screen_y == 10'd0 && !clamped && avg_raw_x == 12'd0)
  `TSQC_ASSERT_IMP(a_clamp_panel, out_valid && clamped,
    valid_res && screen_x == 10'(PANEL_WIDTH) && screen_y == 10'(PANEL_HEIGHT))
  `TSQC_ASSERT_IMP(a_in_bounds, out_valid && valid_res && !clamped,
    screen_x <= 10'(PANEL_WIDTH) && screen_y <= 10'(PANEL_HEIGHT))
  `TSQC_ASSERT_NEXT(a_stall_hold, dl.vld && out_valid && !out_ready,
    dl.vld && out_valid)

endmodule

### tb/tb_top.sv
// Testbench for the touch sample qualify and calibrate block: predictor, stimulus, checker
module tb_top
  import tsqc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 37;
  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic [11:0] first_raw_x, first_raw_y, second_raw_x, second_raw_y;
  logic        out_valid, out_ready;
  logic        valid_res;
  logic [11:0] avg_raw_x, avg_raw_y;
  logic [9:0]  screen_x, screen_y;
  logic        clamped;

  typedef struct packed {
    logic        agree;
    logic [11:0] ax;
    logic [11:0] ay;
    logic [9:0]  sx;
    logic [9:0]  sy;
    logic        clamp;
  } touch_point_t;

  // calibration mirror
  logic [31:0] cal_regs [8];

  touch_point_t pending_points[$];
  int  mismatches;
  int  idle_cycles;
  bit  rx_hold;
  bit  rx_busy;

  touch_sample_qualify_calibrate_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // map one axis: wrapping 32-bit sum, truncating divide, low 16 bits
  function automatic logic [15:0] map_axis(logic [31:0] off, logic [31:0] gx,
                                           logic [31:0] gy, logic [11:0] ax,
                                           logic [11:0] ay, logic [30:0] div);
    logic [31:0] sum;
    longint      q;
    sum = off + gx * {20'd0, ax} + gy * {20'd0, ay};
    if (div == 0) q = 0;
    else q = longint'($signed(sum)) / longint'({33'd0, div});
    return q[15:0];
  endfunction

  function automatic touch_point_t predict_point(logic [11:0] x1, logic [11:0] y1,
                                                 logic [11:0] x2, logic [11:0] y2);
    touch_point_t p;
    logic [12:0]  dx, dy, thr;
    logic [12:0]  sx13, sy13;
    logic [15:0]  sx, sy;
    p   = '0;
    thr = cal_regs[REG_THRESHOLD][12:0];
    dx  = (x1 > x2) ? x1 - x2 : x2 - x1;
    dy  = (y1 > y2) ? y1 - y2 : y2 - y1;
    if (!(dx < thr && dy < thr)) return p;
    sx13 = x1 + x2;
    sy13 = y1 + y2;
    p.agree = 1'b1;
    p.ax = sx13[12:1];
    p.ay = sy13[12:1];
    sx = map_axis(cal_regs[REG_X_OFFSET], cal_regs[REG_X_GAIN_X], cal_regs[REG_X_GAIN_Y],
                  p.ax, p.ay, cal_regs[REG_SCALE][30:0]);
    sy = map_axis(cal_regs[REG_Y_OFFSET], cal_regs[REG_Y_GAIN_X], cal_regs[REG_Y_GAIN_Y],
                  p.ax, p.ay, cal_regs[REG_SCALE][30:0]);
    if (sx > PANEL_WIDTH || sy > PANEL_HEIGHT) begin
      sx = PANEL_WIDTH;
      sy = PANEL_HEIGHT;
      p.clamp = 1'b1;
    end
    p.sx = sx[9:0];
    p.sy = sy[9:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // random gap, mostly short, sometimes long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result checker
  always @(posedge clk) begin
    touch_point_t exp_pt;
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        exp_pt = pending_points.pop_front();
        if (valid_res !== exp_pt.agree) report_mismatch("valid_res", valid_res, exp_pt.agree);
        if (avg_raw_x !== exp_pt.ax) report_mismatch("avg_raw_x", avg_raw_x, exp_pt.ax);
        if (avg_raw_y !== exp_pt.ay) report_mismatch("avg_raw_y", avg_raw_y, exp_pt.ay);
        if (screen_x !== exp_pt.sx) report_mismatch("screen_x", screen_x, exp_pt.sx);
        if (screen_y !== exp_pt.sy) report_mismatch("screen_y", screen_y, exp_pt.sy);
        if (clamped !== exp_pt.clamp) report_mismatch("clamped", clamped, exp_pt.clamp);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (rx_hold) begin
        rx_busy = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
        rx_busy = 1'b0;
      end else if (rx_busy) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0 && $urandom_range(0, 3) != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog: cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one APB write, after which the bus is left idle
  task automatic write_cal(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk iff pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SCALE:     cal_regs[idx] = {1'b0, value[30:0]};
      REG_THRESHOLD: cal_regs[idx] = {19'd0, value[12:0]};
      default:       cal_regs[idx] = value;
    endcase
    @(posedge clk);
  endtask

  // send one word; hold valid across back-to-back words
  task automatic send_pair(logic [11:0] x1, logic [11:0] y1, logic [11:0] x2,
                           logic [11:0] y2, bit with_gaps);
    int gap;
    gap = with_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    first_raw_x  <= x1;
    first_raw_y  <= y1;
    second_raw_x <= x2;
    second_raw_y <= y2;
    @(posedge clk iff in_ready);
    pending_points.push_back(predict_point(x1, y1, x2, y2));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_points.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // random pair: mostly close readings, some far apart
  task automatic send_random(bit with_gaps);
    logic [11:0] x1, y1, x2, y2;
    int spread;
    x1 = $urandom_range(0, 4095);
    y1 = $urandom_range(0, 4095);
    if ($urandom_range(0, 9) < 8) begin
      spread = cal_regs[REG_THRESHOLD] + 2;
      x2 = 12'(int'(x1) + $urandom_range(0, spread) - spread / 2);
      y2 = 12'(int'(y1) + $urandom_range(0, spread) - spread / 2);
      if (x2 > 4095 || (int'(x1) + spread > 4095 && x2 < x1 - spread)) x2 = x1;
    end else begin
      x2 = $urandom_range(0, 4095);
      y2 = $urandom_range(0, 4095);
    end
    send_pair(x1, y1, x2, y2, with_gaps);
  endtask

  task automatic test_directed();
    send_pair(12'd0, 12'd0, 12'd0, 12'd0, 0);
    send_pair(12'd4095, 12'd4095, 12'd4095, 12'd4095, 0);
    send_pair(12'd4095, 12'd0, 12'd4046, 12'd49, 0);
    send_pair(12'd100, 12'd100, 12'd150, 12'd100, 0);
    send_pair(12'd100, 12'd100, 12'd100, 12'd50, 0);
    send_pair(12'd0, 12'd4095, 12'd4095, 12'd0, 0);
    send_pair(12'd480, 12'd272, 12'd481, 12'd273, 0);
    send_pair(12'd479, 12'd271, 12'd480, 12'd272, 0);
    send_pair(12'd1000, 12'd100, 12'd1001, 12'd100, 0);
    send_pair(12'd100, 12'd1000, 12'd100, 12'd1001, 0);
    send_pair(12'hAAA, 12'h555, 12'hAAA, 12'h555, 0);
    send_pair(12'h555, 12'hAAA, 12'h555, 12'hAAA, 0);
    drain();
  endtask

  // extreme and unusual calibrations
  task automatic test_extreme_cal();
    write_cal(REG_X_OFFSET, 32'h8000_0000);
    write_cal(REG_X_GAIN_X, 32'h7FFF_FFFF);
    write_cal(REG_X_GAIN_Y, 32'h8000_0000);
    write_cal(REG_Y_OFFSET, 32'h7FFF_FFFF);
    write_cal(REG_Y_GAIN_X, 32'hFFFF_FFFF);
    write_cal(REG_Y_GAIN_Y, 32'h0000_0001);
    write_cal(REG_SCALE, 32'h7FFF_FFFF);
    write_cal(REG_THRESHOLD, 32'd4096);
    repeat (40) send_random(1);
    send_pair(12'd0, 12'd4095, 12'd4095, 12'd0, 0);
    drain();
    write_cal(REG_SCALE, 32'd1);
    write_cal(REG_THRESHOLD, 32'd1);
    send_pair(12'd7, 12'd9, 12'd7, 12'd9, 0);
    send_pair(12'd7, 12'd9, 12'd8, 12'd9, 0);
    repeat (30) send_random(1);
    drain();
    // zero divisor and zero threshold
    write_cal(REG_SCALE, 32'h8000_0000);
    write_cal(REG_THRESHOLD, 32'h0000_2000);
    send_pair(12'd5, 12'd5, 12'd5, 12'd5, 0);
    drain();
    write_cal(REG_THRESHOLD, 32'd4096);
    repeat (20) send_random(0);
    drain();
  endtask

  // plausible calibrations with random content
  task automatic test_random_cal(int n);
    write_cal(REG_X_OFFSET, $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 20000)));
    write_cal(REG_X_GAIN_X, 32'($urandom_range(0, 9000)) - 32'd1000);
    write_cal(REG_X_GAIN_Y, $urandom_range(0, 3) == 0 ? $urandom() : 32'($urandom_range(0, 400)));
    write_cal(REG_Y_OFFSET, 32'($urandom_range(0, 20000)) - 32'd2000);
    write_cal(REG_Y_GAIN_X, $urandom_range(0, 3) == 0 ? $urandom() : 32'($urandom_range(0, 400)));
    write_cal(REG_Y_GAIN_Y, 32'($urandom_range(0, 6000)));
    write_cal(REG_SCALE, $urandom_range(0, 4) == 0 ? $urandom() : 32'($urandom_range(1, 40)));
    write_cal(REG_THRESHOLD, $urandom_range(0, 3) == 0 ? 32'($urandom_range(1, 4096))
                                                       : 32'($urandom_range(1, 200)));
    repeat (n) send_random(1);
    drain();
  endtask

  // receiver holds off while words keep coming, so the pipeline backs up
  task automatic test_backpressure();
    rx_hold = 1'b1;
    repeat (120) send_random(0);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0;
    first_raw_x = '0; first_raw_y = '0; second_raw_x = '0; second_raw_y = '0;
    mismatches = 0;
    rx_hold = 1'b0;
    rx_busy = 1'b0;
    cal_regs = '{32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd65536, 32'd50};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extreme_cal();
    for (int i = 0; i < 10; i++) test_random_cal(115);
    test_backpressure();
    test_random_cal(50);
    drain();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
